// ===== hw/rtl/utf8_stream_sanitizer_defines.svh =====
// assertion macros shared by the utf8 stream sanitizer rtl
// no dependencies; included by the modules that carry assertions
`ifndef UTF8_STREAM_SANITIZER_DEFINES_SVH
`define UTF8_STREAM_SANITIZER_DEFINES_SVH

// condition holds in the same cycle
`define U8S_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 sanitizer check failed");

// condition holds in the next cycle
`define U8S_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 sanitizer check failed");

`endif

// ===== hw/rtl/u8s_pkg.sv =====
// types, constants and byte classification for the utf8 stream sanitizer
// no dependencies
`timescale 1ns / 1ps

package u8s_pkg;

    localparam logic [7:0] QMARK      = 8'h3F;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] E0_LO      = 8'hA0;
    localparam logic [7:0] ED_HI      = 8'h9F;
    localparam logic [7:0] F0_LO      = 8'h90;
    localparam logic [7:0] F4_HI      = 8'h8F;
    localparam int         GROUP_MAX  = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } out_word_t;

    typedef struct packed {
        logic [2:0]       count;
        logic [3:0][7:0]  bytes;
        logic             text_end;
    } group_t;

    // expected sequence length of a lead byte, 0 for ascii or a bad lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = 3'd0;
            if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                len = 3'd2;
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                len = 3'd3;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                len = 3'd4;
            end
            return len;
        end
    endfunction

    // continuation byte range at position pos after the lead
    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        begin
            lo = CONT_LO;
            hi = CONT_HI;
            if (pos == 2'd1)
            begin
                if (lead == LEAD_E0)
                begin
                    lo = E0_LO;
                end
                else if (lead == LEAD_ED)
                begin
                    hi = ED_HI;
                end
                else if (lead == LEAD_F0)
                begin
                    lo = F0_LO;
                end
                else if (lead == LEAD_F4)
                begin
                    hi = F4_HI;
                end
            end
            return (b >= lo) && (b <= hi);
        end
    endfunction

endpackage

// ===== hw/rtl/utf8_stream_sanitizer.sv =====
// Streaming UTF-8 sanitizer, one byte word in, one byte word out.
// Input channel text_*: text_word carries in_byte and text_end (last byte of a text).
// Output channel clean_*: clean_word carries out_byte, run_last (last result of
// one input word) and text_done (last result of the whole text).
// Each channel moves a word on a rising edge with valid high and stall low.
// Bytes of a well-formed sequence leave unchanged; a failed sequence turns its
// held bytes into '?', bad leads become '?', and text_end flushes an open
// sequence as '?'. Output word count equals input word count.
// The results of a word appear in the cycle after it is taken.
// Throughput: one word per cycle while each word yields at most one result; a
// word that closes or breaks a sequence yields up to four results, drained one
// per cycle from the result group register, which holds the input for that long.
// The input is taken again in the cycle the last result of the group leaves.
// When the receiver stalls, the current result holds and the input stalls once
// a group is waiting. Reset clears the open sequence and the result group.
// depends on u8s_pkg, u8s_step and utf8_stream_sanitizer_defines.svh
`timescale 1ns / 1ps
`include "utf8_stream_sanitizer_defines.svh"

module utf8_stream_sanitizer
    import u8s_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      text_valid,
    output logic      text_stall,
    input  in_word_t  text_word,
    output logic      clean_valid,
    input  logic      clean_stall,
    output out_word_t clean_word
);

    group_t           group;
    logic             take;
    logic             last;
    logic             drain;
    logic [2:0]       cnt_reg;
    logic [1:0]       pos_reg;
    logic [3:0][7:0]  bytes_reg;
    logic             end_reg;

    assign clean_valid = cnt_reg != 3'd0;
    assign last        = ({1'b0, pos_reg} + 3'd1) == cnt_reg;
    assign drain       = clean_valid && !clean_stall;
    assign text_stall  = !((cnt_reg == 3'd0) || (drain && last));
    assign take        = text_valid && !text_stall;

    assign clean_word.out_byte  = bytes_reg[pos_reg];
    assign clean_word.run_last  = last;
    assign clean_word.text_done = last && end_reg;

    u8s_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .word  (text_word),
        .group (group)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            pos_reg <= 2'd0;
        end
        else if (take)
        begin
            cnt_reg <= group.count;
            pos_reg <= 2'd0;
        end
        else if (drain)
        begin
            if (last)
            begin
                cnt_reg <= 3'd0;
                pos_reg <= 2'd0;
            end
            else
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            bytes_reg <= group.bytes;
            end_reg   <= group.text_end;
        end
    end

    `U8S_ASSERT_IMP(a_pos_in_group, clk, rst_n, clean_valid, {1'b0, pos_reg} < cnt_reg)
    `U8S_ASSERT_NXT(a_group_loaded, clk, rst_n, take, cnt_reg == $past(group.count))
    `U8S_ASSERT_NXT(a_stall_holds, clk, rst_n, clean_valid && clean_stall, clean_valid && $stable(clean_word))

endmodule

// ===== hw/rtl/u8s_step.sv =====
// sequence tracker: held bytes, open sequence state and the result group of one word
// depends on u8s_pkg and utf8_stream_sanitizer_defines.svh
`timescale 1ns / 1ps
`include "utf8_stream_sanitizer_defines.svh"

module u8s_step
    import u8s_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_word_t word,
    output group_t   group
);

    logic [7:0] held_reg [3];
    logic [1:0] hc_reg;
    logic [1:0] hc_next;
    logic [2:0] sl_reg;
    logic [2:0] sl_next;

    logic [7:0] b;
    logic       open_seq;
    logic       ok;
    logic       complete;
    logic       extend;
    logic       fail;
    logic       relead;
    logic [2:0] len;
    logic       lead_emit;
    logic       lead_hold;
    logic [7:0] lead_byte;
    logic [2:0] n_pre;
    logic [2:0] n_post;
    logic [1:0] hc_step;
    logic [2:0] sl_step;

    always_comb
    begin
        b         = word.in_byte;
        open_seq  = hc_reg != 2'd0;
        ok        = cont_ok(held_reg[0], hc_reg, b);
        complete  = open_seq && ok && (({1'b0, hc_reg} + 3'd1) == sl_reg);
        extend    = open_seq && ok && !complete;
        fail      = open_seq && !ok;
        relead    = !open_seq || fail;
        len       = lead_len(b);
        lead_emit = relead && (len == 3'd0);
        lead_hold = relead && (len != 3'd0);
        lead_byte = b[7] ? QMARK : b;

        n_pre = 3'd0;
        if (complete)
        begin
            n_pre = {1'b0, hc_reg} + 3'd1;
        end
        else if (fail)
        begin
            n_pre = {1'b0, hc_reg};
        end

        hc_step = 2'd0;
        sl_step = 3'd0;
        if (extend)
        begin
            hc_step = hc_reg + 2'd1;
            sl_step = sl_reg;
        end
        else if (lead_hold)
        begin
            hc_step = 2'd1;
            sl_step = len;
        end

        // end of text flushes whatever is still open
        n_post  = 3'd0;
        hc_next = hc_step;
        sl_next = sl_step;
        if (word.text_end)
        begin
            n_post  = {1'b0, hc_step};
            hc_next = 2'd0;
            sl_next = 3'd0;
        end

        group.count    = n_pre + {2'b00, lead_emit} + n_post;
        group.text_end = word.text_end;
        for (int k = 0; k < GROUP_MAX; k++)
        begin
            group.bytes[k] = QMARK;
            if (lead_emit && (n_pre == 3'(k)))
            begin
                group.bytes[k] = lead_byte;
            end
        end
        if (complete)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < hc_reg)
                begin
                    group.bytes[k] = held_reg[k];
                end
            end
            group.bytes[hc_reg] = b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= 2'd0;
            sl_reg <= 3'd0;
        end
        else if (take)
        begin
            hc_reg <= hc_next;
            sl_reg <= sl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && extend)
        begin
            held_reg[hc_reg] <= b;
        end
        else if (take && lead_hold)
        begin
            held_reg[0] <= b;
        end
    end

    `U8S_ASSERT_IMP(a_open_shorter, clk, rst_n, hc_reg != 2'd0, {1'b0, hc_reg} < sl_reg)
    `U8S_ASSERT_NXT(a_end_closes, clk, rst_n, take && word.text_end, hc_reg == 2'd0)
    `U8S_ASSERT_IMP(a_end_emits, clk, rst_n, word.text_end, group.count != 3'd0)

endmodule

// ===== bench/tb_top.sv =====
// testbench for utf8_stream_sanitizer: directed and random byte texts, checked word by word
// against a built-in predictor of the well-formed utf-8 rules; needs u8s_pkg and the rtl
`timescale 1ns / 1ps

module tb_top
    import u8s_pkg::*;
();

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 20;

    logic      clk;
    logic      rst_n;
    logic      text_valid;
    logic      text_stall;
    in_word_t  text_word;
    logic      clean_valid;
    logic      clean_stall = 1'b0;
    out_word_t clean_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // predictor state: bytes of the open sequence, lead first
    logic [7:0] open_bytes [3];
    int         open_count = 0;
    int         open_len = 0;

    out_word_t  run_words [$];
    out_word_t  expected_words [$];
    logic [7:0] char_bytes [$];

    utf8_stream_sanitizer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_word   (text_word),
        .clean_valid (clean_valid),
        .clean_stall (clean_stall),
        .clean_word  (clean_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        clean_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // allowed range of the byte at position pos after the lead
    function automatic void byte_bounds(input logic [7:0] lead, input int pos,
                                        output logic [7:0] lo, output logic [7:0] hi);
        lo = CONT_LO;
        hi = CONT_HI;
        if (pos == 1)
        begin
            if (lead == LEAD_E0)
            begin
                lo = E0_LO;
            end
            else if (lead == LEAD_ED)
            begin
                hi = ED_HI;
            end
            else if (lead == LEAD_F0)
            begin
                lo = F0_LO;
            end
            else if (lead == LEAD_F4)
            begin
                hi = F4_HI;
            end
        end
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        out_word_t r;
        r.out_byte = b;
        r.run_last = 1'b0;
        r.text_done = 1'b0;
        run_words.push_back(r);
    endfunction

    function automatic void flush_open();
        repeat (open_count) emit_byte(QMARK);
        open_count = 0;
        open_len = 0;
    endfunction

    function automatic void open_or_emit(input logic [7:0] b);
        int len;
        len = 0;
        if (b < CONT_LO)
        begin
            emit_byte(b);
            return;
        end
        if (b >= LEAD2_LO && b <= LEAD2_HI)
        begin
            len = 2;
        end
        else if (b >= LEAD3_LO && b <= LEAD3_HI)
        begin
            len = 3;
        end
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
        begin
            len = 4;
        end
        if (len == 0)
        begin
            emit_byte(QMARK);
        end
        else
        begin
            open_bytes[0] = b;
            open_count = 1;
            open_len = len;
        end
    endfunction

    // expected output words of one accepted input word
    function automatic void predict_word(input in_word_t w);
        logic [7:0] lo;
        logic [7:0] hi;
        run_words = {};
        if (open_count != 0)
        begin
            byte_bounds(open_bytes[0], open_count, lo, hi);
            if (w.in_byte >= lo && w.in_byte <= hi)
            begin
                if (open_count + 1 == open_len)
                begin
                    for (int i = 0; i < open_count; i++)
                        emit_byte(open_bytes[i]);
                    emit_byte(w.in_byte);
                    open_count = 0;
                    open_len = 0;
                end
                else
                begin
                    open_bytes[open_count] = w.in_byte;
                    open_count++;
                end
            end
            else
            begin
                flush_open();
                open_or_emit(w.in_byte);
            end
        end
        else
        begin
            open_or_emit(w.in_byte);
        end
        if (w.text_end)
            flush_open();
        if (run_words.size() > 0)
        begin
            run_words[run_words.size() - 1].run_last = 1'b1;
            run_words[run_words.size() - 1].text_done = w.text_end;
        end
        foreach (run_words[i])
            expected_words.push_back(run_words[i]);
    endfunction

    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n && clean_valid && !clean_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: word %h arrived, none expected", $time, clean_word);
                mismatch_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (clean_word.out_byte !== exp_w.out_byte)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, exp_w.out_byte, clean_word.out_byte);
                    mismatch_count++;
                end
                if (clean_word.run_last !== exp_w.run_last)
                begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, exp_w.run_last, clean_word.run_last);
                    mismatch_count++;
                end
                if (clean_word.text_done !== exp_w.text_done)
                begin
                    $display("%0t: text_done expected %b actual %b",
                             $time, exp_w.text_done, clean_word.text_done);
                    mismatch_count++;
                end
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_word(input logic [7:0] b, input logic e);
        in_word_t w;
        w.in_byte = b;
        w.text_end = e;
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(negedge clk);
        end
        text_valid <= 1'b1;
        text_word <= w;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        predict_word(w);
        @(negedge clk);
    endtask

    task automatic pause_until_drained();
        text_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_words.size() != 0);
    endtask

    // one character: well-formed, broken, or a noise byte
    task automatic build_char();
        int kind;
        int len;
        int pos;
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        char_bytes = {};
        kind = $urandom_range(99);
        if (kind >= 80)
        begin
            char_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        len = $urandom_range(4, 1);
        case (len)
            1: lead = 8'($urandom_range(8'h7F));
            2: lead = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
            3: lead = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
            default: lead = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
        endcase
        char_bytes.push_back(lead);
        for (int i = 1; i < len; i++)
        begin
            byte_bounds(lead, i, lo, hi);
            char_bytes.push_back(8'($urandom_range(hi, lo)));
        end
        if (kind >= 50 && len > 1)
        begin
            if ($urandom_range(1) == 0)
            begin
                repeat ($urandom_range(len - 1, 1)) void'(char_bytes.pop_back());
            end
            else
            begin
                pos = $urandom_range(len - 1, 1);
                byte_bounds(lead, pos, lo, hi);
                case ($urandom_range(2))
                    0: char_bytes[pos] = lo - 8'd1;
                    1: char_bytes[pos] = hi + 8'd1;
                    default: char_bytes[pos] = 8'($urandom_range(255));
                endcase
            end
        end
    endtask

    task automatic test_single_bytes();
        send_word(8'h00, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hC1, 1'b0);
        send_word(8'hFF, 1'b0);
    endtask

    task automatic test_sequence_bounds();
        send_word(8'hC2, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hE0, 1'b0);
        send_word(8'hA0, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hF4, 1'b0);
        send_word(8'h8F, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b0);
    endtask

    task automatic test_rejected_forms();
        send_word(8'hE0, 1'b0);
        send_word(8'h9F, 1'b0);
        send_word(8'hED, 1'b0);
        send_word(8'hA0, 1'b0);
        send_word(8'hF4, 1'b0);
        send_word(8'h90, 1'b0);
    endtask

    // zero byte breaking an open sequence, then a flush on end of text
    task automatic test_end_of_text();
        send_word(8'hF1, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'hC3, 1'b1);
    endtask

    task automatic test_random_text(input int send_pct, input int recv_pct, input int n_words);
        int sent;
        sent = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < n_words)
        begin
            if ($urandom_range(39) == 0)
                pause_until_drained();
            build_char();
            foreach (char_bytes[i])
            begin
                send_word(char_bytes[i], $urandom_range(15) == 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        text_valid = 1'b0;
        text_word = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_bytes();
        test_sequence_bounds();
        test_rejected_forms();
        test_end_of_text();
        pause_until_drained();
        test_random_text(17, 80, 65);
        test_random_text(80, 17, 65);
        test_random_text(0, 0, 65);

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
